[rtl/core/cfr_pkg.sv]
// cfr_pkg: shared constants and helpers for the cook command frame receiver
// no dependencies; used by cook_command_frame_receiver_top
package cfr_pkg;

    localparam logic [7:0] CH_START = 8'h3E;
    localparam logic [7:0] CH_END   = 8'h3C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int SEC_W = 14;

    typedef logic [SEC_W-1:0] sec_t;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        POS_START = 3'd0,
        POS_LEVEL = 3'd1,
        POS_D0    = 3'd2,
        POS_D1    = 3'd3,
        POS_D2    = 3'd4,
        POS_D3    = 3'd5,
        POS_CHECK = 3'd6,
        POS_END   = 3'd7
    } parse_pos_t;

    // digit value scaled by its decimal weight (units first)
    function automatic sec_t digit_scaled(input logic [1:0] idx, input logic [3:0] digit);
        sec_t w;
        unique case (idx)
            2'd0: w = 14'd1;
            2'd1: w = 14'd10;
            2'd2: w = 14'd100;
            2'd3: w = 14'd1000;
            default: w = 14'd0;
        endcase
        return sec_t'({10'd0, digit} * w);
    endfunction

    // lowest n relays on for level n
    function automatic logic [2:0] level_mask(input logic [1:0] level);
        logic [2:0] m;
        unique case (level)
            2'd0: m = 3'b000;
            2'd1: m = 3'b001;
            2'd2: m = 3'b011;
            2'd3: m = 3'b111;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/cook_command_frame_receiver_top.sv]
// cook_command_frame_receiver_top: frame parser and cooking countdown
// result beat: registered, valid in the cycle after the input beat is taken
// throughput: one input beat per cycle; a full result register holds input
// back for every cycle that out_ready stays low
// reset: rst_n asynchronous active low, parser idle, no cooking, no result pending
// depends on cfr_pkg
module cook_command_frame_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  relay_mask,
    output logic [13:0] remaining_seconds,
    output logic        cooking,
    output logic        frame_accepted,
    output logic        frame_error
);

    cfr_pkg::parse_pos_t pos_reg, pos_next;
    logic [1:0]          level_reg, level_next;
    cfr_pkg::sec_t       sec_reg, sec_next;
    logic [7:0]          xor_reg, xor_next;
    logic                cook_reg, cook_next;
    logic                acc_next, err_next;

    logic                out_valid_reg;
    logic [2:0]          relay_mask_reg;
    cfr_pkg::sec_t       remaining_seconds_reg;
    logic                cooking_reg;
    logic                frame_accepted_reg;
    logic                frame_error_reg;

    logic                take;
    logic                is_digit, is_level, check_ok;
    logic [1:0]          digit_idx;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign is_digit  = (rx_byte >= cfr_pkg::CH_ZERO) && (rx_byte <= cfr_pkg::CH_NINE);
    assign is_level  = (rx_byte >= cfr_pkg::CH_ZERO) && (rx_byte <= cfr_pkg::CH_THREE);
    assign check_ok  = (rx_byte == xor_reg) ||
                       ((xor_reg >= cfr_pkg::CH_ZERO) && (rx_byte == xor_reg - cfr_pkg::CH_ZERO));
    assign digit_idx = 2'(pos_reg - cfr_pkg::POS_D0);

    always_comb
    begin
        pos_next   = pos_reg;
        level_next = level_reg;
        sec_next   = sec_reg;
        xor_next   = xor_reg;
        cook_next  = cook_reg;
        acc_next   = 1'b0;
        err_next   = 1'b0;
        if (opcode == cfr_pkg::OP_TICK)
        begin
            if (cook_reg)
            begin
                if (sec_reg != '0)
                begin
                    sec_next = sec_reg - 14'd1;
                end
                if (sec_next == '0)
                begin
                    cook_next = 1'b0;
                end
            end
        end
        else if (!cook_reg)
        begin
            unique case (pos_reg)
                cfr_pkg::POS_START:
                begin
                    if (rx_byte == cfr_pkg::CH_START)
                    begin
                        pos_next = cfr_pkg::POS_LEVEL;
                    end
                end
                cfr_pkg::POS_LEVEL:
                begin
                    if (is_level)
                    begin
                        level_next = rx_byte[1:0];
                        xor_next   = xor_reg ^ rx_byte;
                        pos_next   = cfr_pkg::POS_D0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                cfr_pkg::POS_D0, cfr_pkg::POS_D1, cfr_pkg::POS_D2, cfr_pkg::POS_D3:
                begin
                    if (is_digit)
                    begin
                        sec_next = sec_reg + cfr_pkg::digit_scaled(digit_idx, rx_byte[3:0]);
                        xor_next = xor_reg ^ rx_byte;
                        pos_next = cfr_pkg::parse_pos_t'(pos_reg + 3'd1);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                cfr_pkg::POS_CHECK:
                begin
                    if (check_ok)
                    begin
                        pos_next = cfr_pkg::POS_END;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                cfr_pkg::POS_END:
                begin
                    if (rx_byte == cfr_pkg::CH_END)
                    begin
                        acc_next  = 1'b1;
                        pos_next  = cfr_pkg::POS_START;
                        xor_next  = '0;
                        cook_next = (sec_reg != '0);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
            // bad byte aborts the frame
            if (err_next)
            begin
                pos_next = cfr_pkg::POS_START;
                sec_next = '0;
                xor_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= cfr_pkg::POS_START;
            level_reg     <= '0;
            sec_reg       <= '0;
            xor_reg       <= '0;
            cook_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_reg   <= pos_next;
                level_reg <= level_next;
                sec_reg   <= sec_next;
                xor_reg   <= xor_next;
                cook_reg  <= cook_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            relay_mask_reg        <= cook_next ? cfr_pkg::level_mask(level_next) : 3'b000;
            remaining_seconds_reg <= sec_next;
            cooking_reg           <= cook_next;
            frame_accepted_reg    <= acc_next;
            frame_error_reg       <= err_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign relay_mask        = relay_mask_reg;
    assign remaining_seconds = remaining_seconds_reg;
    assign cooking           = cooking_reg;
    assign frame_accepted    = frame_accepted_reg;
    assign frame_error       = frame_error_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(frame_accepted_reg && frame_error_reg))
        else $error("accept and error flagged on one beat");

    a_relays_only_cooking: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (relay_mask_reg != 3'b000)) |-> cooking_reg)
        else $error("relays on while not cooking");

    a_cook_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        cook_reg |-> (sec_reg != '0))
        else $error("cooking with zero seconds left");

    a_idle_parser_while_cooking: assert property (@(posedge clk) disable iff (!rst_n)
        cook_reg |-> (pos_reg == cfr_pkg::POS_START))
        else $error("parser mid-frame while cooking");
`endif

endmodule
